/* design/mass_weighted_centroid_distance_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the centroid distance block
// Clocked property wrappers that share one clock, reset and message.
// ---------------------------------------------------------------------------
`ifndef MASS_WEIGHTED_CENTROID_DISTANCE_ASSERT_SVH
`define MASS_WEIGHTED_CENTROID_DISTANCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MWCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("centroid distance check failed");

// Next-cycle implication, checked outside reset.
`define MWCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("centroid distance check failed");

// Delayed implication, checked outside reset.
`define MWCD_ASSERT_AFTER7(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##7 (cons)) \
    else $error("centroid distance check failed");

`endif

/* design/mwcd_pkg.sv */
// ---------------------------------------------------------------------------
// mwcd_pkg
// Shared widths, types and state codes of the centroid distance block.
// ---------------------------------------------------------------------------
package mwcd_pkg;

  localparam int DEF_ATOM_COUNT_LOG2 = 16;
  localparam int POS_W    = 32;
  localparam int MASS_IN_W = 16;
  localparam int PROD_W   = 48;
  localparam int DIST_W   = 33;
  localparam int SQ_W     = 68;
  localparam int ROOT_W   = 34;
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = 18;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  // Status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_MUL       = 10'b0000000010,
    S_ACC       = 10'b0000000100,
    S_DIV_START = 10'b0000001000,
    S_DIV_WAIT  = 10'b0000010000,
    S_SQ_MUL    = 10'b0000100000,
    S_SQ_ACC    = 10'b0001000000,
    S_RT_START  = 10'b0010000000,
    S_RT_WAIT   = 10'b0100000000,
    S_OUT       = 10'b1000000000
  } state_t;

endpackage

/* design/mwcd_div.sv */
// ---------------------------------------------------------------------------
// mwcd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mwcd_div import mwcd_pkg::*; #(
  parameter int SUM_W  = 64,
  parameter int MASS_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [MASS_W-1:0] divisor,
  output logic [SUM_W-1:0]  quotient,
  output unit_stat_t        stat
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  count;
  logic [MASS_W-1:0] rem;
  logic [MASS_W-1:0] dvs;
  logic [SUM_W-1:0]  work;
  logic [MASS_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, work[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        count     <= CNT_W'(SUM_W);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      work <= dividend;
    end else if (stat.busy) begin
      rem  <= fits ? MASS_W'(rem_sh - {1'b0, dvs}) : rem_sh[MASS_W-1:0];
      work <= {work[SUM_W-2:0], fits};
    end
  end

  assign quotient = work;

endmodule

/* design/mwcd_sqrt.sv */
// ---------------------------------------------------------------------------
// mwcd_sqrt
// Digit-by-digit floored square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module mwcd_sqrt import mwcd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic [ROOT_W-1:0] root,
  output unit_stat_t        stat
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [CNT_W-1:0]  count;
  logic [SQ_W-1:0]   work;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              fits;

  assign rem_sh = {rem[ROOT_W-1:0], work[SQ_W-1:SQ_W-2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        count     <= CNT_W'(ROOT_W);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (stat.busy) begin
      work <= {work[SQ_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

/* design/mass_weighted_centroid_distance.sv */
// ---------------------------------------------------------------------------
// mass_weighted_centroid_distance
// Centers of mass of two atom groups and the distance between them.
// ---------------------------------------------------------------------------
// Each accepted atom request passes through the accepting cycle, then three
// multiply and add steps in which one shared signed multiplier forms mass
// times position for x, y and z in turn, and each product is added into the
// sums of the groups the atom belongs to. The atom marked last then runs the
// result phase: six restoring divisions (none is run for an empty group),
// nine multiply-add steps on the same multiplier for the squared differences,
// and a square root. The block takes no atom while it works, but a finished
// result waits in its output register without holding up the next atom.
// Centers are truncated toward zero and saturate at the signed 32-bit range;
// an empty group gives a zero center and raises its empty flag.
// ---------------------------------------------------------------------------
module mass_weighted_centroid_distance import mwcd_pkg::*; #(
  parameter int ATOM_COUNT_LOG2 = DEF_ATOM_COUNT_LOG2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [MASS_IN_W-1:0]  atom_mass,
  input  logic                  in_group_a,
  input  logic                  in_group_b,
  input  logic                  last_atom,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [POS_W-1:0] centre_x,
  output logic signed [POS_W-1:0] centre_y,
  output logic signed [POS_W-1:0] centre_z,
  output logic [DIST_W-1:0]     centre_distance,
  output logic                  group_a_empty,
  output logic                  group_b_empty
);

  `include "mass_weighted_centroid_distance_assert.svh"

  localparam int SUM_W  = PROD_W + ATOM_COUNT_LOG2;
  localparam int MASS_W = MASS_IN_W + ATOM_COUNT_LOG2;

  state_t state;

  // Latched atom.
  logic [POS_W-1:0]     atom_pos [3];
  logic [MASS_IN_W-1:0] atom_m;
  logic                 atom_a;
  logic                 atom_b;
  logic                 atom_last;

  // Accumulators.
  logic [SUM_W-1:0]  sum_a [3];
  logic [SUM_W-1:0]  sum_b [3];
  logic [MASS_W-1:0] total_a;
  logic [MASS_W-1:0] total_b;

  // Sequencing counters.
  logic [1:0] axis;
  logic [1:0] part;
  logic [2:0] div_idx;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  // Centers and distance work.
  logic [POS_W-1:0] cen_a [3];
  logic [POS_W-1:0] cen_b [3];
  logic [SQ_W-1:0]  sq_acc;
  logic             div_neg;

  logic [1:0]        div_axis;
  logic              div_grp_b;
  logic [SUM_W-1:0]  div_sum;
  logic [MASS_W-1:0] div_total;
  logic [SUM_W-1:0]  div_mag;
  logic [SUM_W-1:0]  quotient;
  logic [POS_W-1:0]  div_centre;
  logic              div_start;
  unit_stat_t        div_stat;

  logic signed [POS_W:0] diff;
  logic [POS_W:0]        diff_mag;
  logic [16:0]           mag_lo;
  logic [15:0]           mag_hi;
  logic [SQ_W-1:0]       part_term;

  logic              rt_start;
  logic [ROOT_W-1:0] root;
  unit_stat_t        rt_stat;

  logic out_load;

  assign in_ready = (state == S_IDLE);

  // Group A centers come first, then group B.
  assign div_grp_b = (div_idx >= 3'd3);
  assign div_axis  = div_grp_b ? 2'(div_idx - 3'd3) : div_idx[1:0];
  assign div_sum   = div_grp_b ? sum_b[div_axis] : sum_a[div_axis];
  assign div_total = div_grp_b ? total_b : total_a;
  assign div_mag   = div_sum[SUM_W-1] ? SUM_W'(~div_sum + 1'b1) : div_sum;
  assign div_start = (state == S_DIV_START) && (div_total != '0);

  // Truncated quotient, clamped at the signed 32-bit limits.
  always_comb begin
    if (div_neg) begin
      if ((|quotient[SUM_W-1:POS_W]) || (quotient[POS_W-1] && (|quotient[POS_W-2:0])))
        div_centre = {1'b1, {(POS_W-1){1'b0}}};
      else
        div_centre = POS_W'(~quotient[POS_W-1:0] + 1'b1);
    end else begin
      if (|quotient[SUM_W-1:POS_W-1])
        div_centre = {1'b0, {(POS_W-1){1'b1}}};
      else
        div_centre = quotient[POS_W-1:0];
    end
  end

  mwcd_div #(
    .SUM_W  (SUM_W),
    .MASS_W (MASS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (div_total),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // The squared difference is built from the 17-bit low and 16-bit high parts
  // of its magnitude: low*low, then low*high shifted by 18 (the doubled cross
  // term), then high*high shifted by 34.
  assign diff     = {cen_b[axis][POS_W-1], cen_b[axis]} - {cen_a[axis][POS_W-1], cen_a[axis]};
  assign diff_mag = diff[POS_W] ? (POS_W+1)'(~diff + 1'b1) : diff;
  assign mag_lo   = diff_mag[16:0];
  assign mag_hi   = diff_mag[POS_W:17];

  always_comb begin
    if (state == S_MUL) begin
      mul_a = MUL_A_W'(signed'(atom_pos[axis]));
      mul_b = MUL_B_W'(signed'({1'b0, atom_m}));
    end else begin
      case (part)
        2'd0: begin
          mul_a = MUL_A_W'(signed'({1'b0, mag_lo}));
          mul_b = MUL_B_W'(signed'({1'b0, mag_lo}));
        end
        2'd1: begin
          mul_a = MUL_A_W'(signed'({1'b0, mag_hi}));
          mul_b = MUL_B_W'(signed'({1'b0, mag_lo}));
        end
        default: begin
          mul_a = MUL_A_W'(signed'({1'b0, mag_hi}));
          mul_b = MUL_B_W'(signed'({1'b0, mag_hi}));
        end
      endcase
    end
  end

  always_comb begin
    case (part)
      2'd0:    part_term = SQ_W'(prod[ROOT_W-1:0]);
      2'd1:    part_term = SQ_W'(prod[ROOT_W-1:0]) << 18;
      default: part_term = SQ_W'(prod[ROOT_W-1:0]) << 34;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == S_MUL) || (state == S_SQ_MUL)) prod <= mul_a * mul_b;
  end

  assign rt_start = (state == S_RT_START);

  mwcd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (rt_start),
    .radicand (sq_acc),
    .root     (root),
    .stat     (rt_stat)
  );

  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      axis    <= '0;
      part    <= '0;
      div_idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
            axis  <= '0;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (axis == 2'd2) begin
            axis    <= '0;
            div_idx <= '0;
            state   <= atom_last ? S_DIV_START : S_IDLE;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_MUL;
          end
        end
        S_DIV_START: begin
          if (div_total != '0) begin
            state <= S_DIV_WAIT;
          end else if (div_idx == 3'd5) begin
            state <= S_SQ_MUL;
            axis  <= '0;
            part  <= '0;
          end else begin
            div_idx <= div_idx + 1'b1;
          end
        end
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            if (div_idx == 3'd5) begin
              state <= S_SQ_MUL;
              axis  <= '0;
              part  <= '0;
            end else begin
              div_idx <= div_idx + 1'b1;
              state   <= S_DIV_START;
            end
          end
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (part == 2'd2) begin
            part <= '0;
            if (axis == 2'd2) begin
              axis  <= '0;
              state <= S_RT_START;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_SQ_MUL;
            end
          end else begin
            part  <= part + 1'b1;
            state <= S_SQ_MUL;
          end
        end
        S_RT_START: state <= S_RT_WAIT;
        S_RT_WAIT: begin
          if (rt_stat.done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Atom capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      atom_pos[0] <= pos_x;
      atom_pos[1] <= pos_y;
      atom_pos[2] <= pos_z;
      atom_m      <= atom_mass;
      atom_a      <= in_group_a;
      atom_b      <= in_group_b;
      atom_last   <= last_atom;
    end
  end

  // Accumulators wrap at their widths and clear once a result is issued.
  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      for (int i = 0; i < 3; i++) begin
        sum_a[i] <= '0;
        sum_b[i] <= '0;
      end
      total_a <= '0;
      total_b <= '0;
    end else if (state == S_ACC) begin
      if (atom_a) sum_a[axis] <= sum_a[axis] + SUM_W'(signed'(prod[PROD_W-1:0]));
      if (atom_b) sum_b[axis] <= sum_b[axis] + SUM_W'(signed'(prod[PROD_W-1:0]));
      if (axis == 2'd2) begin
        if (atom_a) total_a <= total_a + MASS_W'(atom_m);
        if (atom_b) total_b <= total_b + MASS_W'(atom_m);
      end
    end
  end

  // Centers and the sum of squares.
  always_ff @(posedge clk) begin
    if (div_start) div_neg <= div_sum[SUM_W-1];
    if (state == S_DIV_START && div_total == '0) begin
      if (div_grp_b) cen_b[div_axis] <= '0;
      else           cen_a[div_axis] <= '0;
    end
    if (state == S_DIV_WAIT && div_stat.done) begin
      if (div_grp_b) cen_b[div_axis] <= div_centre;
      else           cen_a[div_axis] <= div_centre;
    end
    if (state == S_DIV_START && div_idx == 3'd0) sq_acc <= '0;
    if (state == S_SQ_ACC) sq_acc <= sq_acc + part_term;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      centre_x        <= cen_a[0];
      centre_y        <= cen_a[1];
      centre_z        <= cen_a[2];
      centre_distance <= root[ROOT_W-1] ? {DIST_W{1'b1}} : root[DIST_W-1:0];
      group_a_empty   <= (total_a == '0);
      group_b_empty   <= (total_b == '0);
    end
  end

  // An atom that is not last returns the block to idle.
  `MWCD_ASSERT_AFTER7(a_plain_atom_seven_cycles, in_valid && in_ready && !last_atom, in_ready)
  // The divider only runs while the sequencer waits on it.
  `MWCD_ASSERT_NOW(a_div_busy_in_wait, div_stat.busy, state == S_DIV_WAIT)
  // Loading a result always presents it on the next cycle.
  `MWCD_ASSERT_NEXT(a_load_shows_result, out_load, out_valid && in_ready)

endmodule
